@@ hw/rtl/hcbp_pkg.sv @@
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int SYMBOL_COUNT_DEF  = 256;
  localparam int MAX_CODE_BITS_DEF = 32;

  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int WORD_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int PEND_W = 7;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic look;
    logic flush;
  } pack_ctrl_t;

endpackage

@@ hw/rtl/hcbp_ram.sv @@
`timescale 1ns / 1ps

module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/hcbp_pack.sv @@
`timescale 1ns / 1ps

module hcbp_pack
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  localparam int CW   = MAX_CODE_BITS,
  localparam int AW   = CW + PEND_W,
  localparam int BW   = ((AW + 7) / 8) * 8,
  localparam int TW   = $clog2(BW + 1),
  localparam int KMAX = AW / 8,
  localparam int KW   = $clog2(KMAX + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  pack_ctrl_t       ctrl,
  input  logic [CW-1:0]    entry_word,
  input  logic [LEN_W-1:0] entry_len,
  output logic             pending_empty,
  output logic [AW-1:0]    combined,
  output logic [TW-1:0]    total,
  output logic [KW-1:0]    bytes
);

  logic [PEND_W-1:0] pending;
  logic [2:0]        count;
  logic [AW-1:0]     combined_next;
  logic [TW-1:0]     total_next;
  logic [PEND_W-1:0] pending_next;

  assign pending_empty = (count == 3'd0);

  always_comb begin
    combined_next = ({{CW{1'b0}}, pending} << entry_len) | {{PEND_W{1'b0}}, entry_word};
    total_next    = TW'(count) + TW'(entry_len);
    pending_next  = combined_next[PEND_W-1:0] & ~({PEND_W{1'b1}} << total_next[2:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      count   <= '0;
    end else if (ctrl.look) begin
      pending <= pending_next;
      count   <= total_next[2:0];
    end else if (ctrl.flush) begin
      pending <= '0;
      count   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.look) begin
      combined <= combined_next;
      total    <= total_next;
      bytes    <= KW'(total_next >> 3);
    end else if (ctrl.flush) begin
      combined <= {{CW{1'b0}}, pending};
      total    <= TW'(count);
      bytes    <= KW'(1);
    end
  end

endmodule

@@ hw/rtl/hcbp_emit.sv @@
`timescale 1ns / 1ps

module hcbp_emit
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  localparam int CW   = MAX_CODE_BITS,
  localparam int AW   = CW + PEND_W,
  localparam int BW   = ((AW + 7) / 8) * 8,
  localparam int TW   = $clog2(BW + 1),
  localparam int KMAX = AW / 8,
  localparam int KW   = $clog2(KMAX + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [AW-1:0]     combined,
  input  logic [TW-1:0]     total,
  input  logic [KW-1:0]     bytes,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] packed_byte,
  output logic              last_of_run
);

  logic [BW-1:0] shreg;
  logic [KW-1:0] remaining;
  logic [TW-1:0] shamt;
  logic          take;

  assign out_valid   = (remaining != '0);
  assign last_of_run = (remaining == KW'(1));
  assign packed_byte = shreg[BW-1 -: BYTE_W];
  assign take        = out_valid && !out_stall;
  assign can_load    = !out_valid || (last_of_run && !out_stall);
  assign shamt       = TW'(BW) - total;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= bytes;
    end else if (take) begin
      remaining <= remaining - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= BW'(combined) << shamt;
    end else if (take) begin
      shreg <= shreg << BYTE_W;
    end
  end

endmodule

@@ hw/rtl/huffman_code_bit_packer_core.sv @@
`timescale 1ns / 1ps

// Variable-length code packer built around a single-port-per-side code table RAM of
// SYMBOL_COUNT entries, each holding a code word and its length. A load word does not
// stall the input. An encode word reads the table, merges the code with the pending
// bits and hands the result to the byte serializer, holding the input stalled until the
// serializer can take it. The serializer sends one byte per cycle while out_stall is
// low, up to four per symbol, and the next word meanwhile reads the table and merges.
// The next result can be handed over as early as the cycle of the previous last byte.
// A flush word with pending bits stalls the input likewise and sends one zero-padded
// byte; a flush with nothing pending does not stall the input and sends nothing. The
// code table has no reset: encoding a symbol that was never loaded gives undefined output.
module huffman_code_bit_packer_core
  import hcbp_pkg::*;
#(
  parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   operation,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [WORD_W-1:0] code_word,
  input  logic [LEN_W-1:0]  code_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] packed_byte,
  output logic              last_of_run
);

  localparam int CW    = MAX_CODE_BITS;
  localparam int MW    = CW + LEN_W;
  localparam int ADDRW = $clog2(SYMBOL_COUNT);
  localparam int AW    = CW + PEND_W;
  localparam int BW    = ((AW + 7) / 8) * 8;
  localparam int TW    = $clog2(BW + 1);
  localparam int KMAX  = AW / 8;
  localparam int KW    = $clog2(KMAX + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_ALIGN = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic             accept;
  logic             in_range;
  logic             wr_en;
  logic             rd_en;
  logic [LEN_W-1:0] len_sat;
  logic [CW-1:0]    word_masked;
  logic [MW-1:0]    rd_data;
  pack_ctrl_t       ctrl;
  logic             pending_empty;
  logic [AW-1:0]    combined;
  logic [TW-1:0]    total;
  logic [KW-1:0]    bytes;
  logic             can_load;
  logic             emit_load;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = ({1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign wr_en    = accept && (operation == OP_LOAD) && in_range;
  assign rd_en    = accept && (operation == OP_ENCODE) && in_range;

  assign len_sat     = (code_length > LEN_W'(CW)) ? LEN_W'(CW) : code_length;
  assign word_masked = code_word[CW-1:0] & ~({CW{1'b1}} << len_sat);

  assign ctrl.look  = (state == ST_LOOK);
  assign ctrl.flush = accept && (operation == OP_FLUSH) && !pending_empty;
  assign emit_load  = (state == ST_ALIGN) && (bytes != '0) && can_load;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (rd_en) begin
          state_next = ST_LOOK;
        end else if (ctrl.flush) begin
          state_next = ST_ALIGN;
        end
      end
      ST_LOOK: begin
        state_next = ST_ALIGN;
      end
      ST_ALIGN: begin
        if ((bytes == '0) || can_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  hcbp_ram #(
    .WIDTH(MW),
    .DEPTH(SYMBOL_COUNT)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(symbol[ADDRW-1:0]),
    .wr_data({word_masked, len_sat}),
    .rd_en  (rd_en),
    .rd_addr(symbol[ADDRW-1:0]),
    .rd_data(rd_data)
  );

  hcbp_pack #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_pack (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .entry_word   (rd_data[MW-1:LEN_W]),
    .entry_len    (rd_data[LEN_W-1:0]),
    .pending_empty(pending_empty),
    .combined     (combined),
    .total        (total),
    .bytes        (bytes)
  );

  hcbp_emit #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (emit_load),
    .combined   (combined),
    .total      (total),
    .bytes      (bytes),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .packed_byte(packed_byte),
    .last_of_run(last_of_run)
  );

endmodule

@@ hw/rtl/hcbp_checker.sv @@
`timescale 1ns / 1ps

module hcbp_checker
  import hcbp_pkg::*;
#(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [OP_W-1:0]   operation,
  input logic [SYM_W-1:0]  symbol,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] packed_byte,
  input logic              last_of_run
);

  logic accept;

  assign accept = in_valid && !in_stall;

  // A load word never leaves the input stalled after it is accepted.
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_LOAD) |=> !in_stall)
    else $error("load word kept the input busy");

  // An encode word of a valid symbol waits for its table read.
  a_encode_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_ENCODE) &&
    ({1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT)) |=> in_stall)
    else $error("encode word did not hold off the next input");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(packed_byte) && $stable(last_of_run))
    else $error("stalled output word changed");

endmodule

bind huffman_code_bit_packer_core hcbp_checker #(
  .SYMBOL_COUNT(SYMBOL_COUNT)
) u_hcbp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .operation  (operation),
  .symbol     (symbol),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .packed_byte(packed_byte),
  .last_of_run(last_of_run)
);

@@ dv/huffman_code_bit_packer_core_tb.sv @@
`timescale 1ns / 1ps

module huffman_code_bit_packer_core_tb;
  import hcbp_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RESET_CYCLES = 11;
  localparam int NUM_DIR      = 25;
  localparam int RANDOM_WORDS = 420;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 32;
  localparam int IDLE_LIMIT   = 2000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_byte_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  sym;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
    logic              typed;
    logic [2:0]        count;
    logic [31:0]       bytes;
  } stim_row_t;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic [OP_W-1:0]   operation   = OP_LOAD;
  logic [SYM_W-1:0]  symbol      = '0;
  logic [WORD_W-1:0] code_word   = '0;
  logic [LEN_W-1:0]  code_length = '0;
  logic              out_stall   = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [BYTE_W-1:0] packed_byte;
  logic              last_of_run;

  logic [WORD_W-1:0] tab_code [SYMBOL_COUNT_DEF];
  logic [LEN_W-1:0]  tab_len [SYMBOL_COUNT_DEF];
  bit                loaded [SYMBOL_COUNT_DEF];
  int                loaded_syms[$];
  logic [PEND_W-1:0] acc_bits  = '0;
  logic [2:0]        acc_count = '0;

  out_byte_t pred_bytes[$];
  out_byte_t bytes_due[$];
  stim_row_t dir_rows [NUM_DIR];

  int errors      = 0;
  int idle_cycles = 0;
  int send_left   = 0;
  bit send_quiet  = 1'b0;
  int recv_left   = 0;
  bit recv_quiet  = 1'b0;

  huffman_code_bit_packer_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .symbol     (symbol),
    .code_word  (code_word),
    .code_length(code_length),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .packed_byte(packed_byte),
    .last_of_run(last_of_run)
  );

  always #2 clk = ~clk;

  function automatic void pack_word(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                    input logic [WORD_W-1:0] word,
                                    input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0]  n;
    logic [WORD_W-1:0] code;
    logic [BYTE_W-1:0] acc;
    int                cnt;
    out_byte_t         ob;
    pred_bytes.delete();
    case (op)
      OP_LOAD: begin
        n = (len > MAX_CODE_BITS_DEF) ? LEN_W'(MAX_CODE_BITS_DEF) : len;
        tab_len[sym] = n;
        tab_code[sym] = (n >= 32) ? word : (word & ((32'h1 << n) - 32'h1));
        if (!loaded[sym]) begin
          loaded[sym] = 1'b1;
          loaded_syms.push_back(int'(sym));
        end
      end
      OP_ENCODE: begin
        code = tab_code[sym];
        acc = {1'b0, acc_bits};
        cnt = int'(acc_count);
        for (int i = int'(tab_len[sym]) - 1; i >= 0; i--) begin
          acc = {acc[BYTE_W-2:0], code[i]};
          cnt++;
          if (cnt == 8) begin
            ob.data = acc;
            ob.last = 1'b0;
            pred_bytes.push_back(ob);
            acc = '0;
            cnt = 0;
          end
        end
        if (pred_bytes.size() > 0) begin
          ob = pred_bytes.pop_back();
          ob.last = 1'b1;
          pred_bytes.push_back(ob);
        end
        acc_bits = acc[PEND_W-1:0];
        acc_count = 3'(cnt);
      end
      OP_FLUSH: begin
        if (acc_count != 0) begin
          ob.data = {1'b0, acc_bits} << (8 - int'(acc_count));
          ob.last = 1'b1;
          pred_bytes.push_back(ob);
          acc_bits = '0;
          acc_count = '0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int send_gap();
    if (send_left == 0) begin
      send_quiet = ($urandom_range(0, 3) == 0);
      send_left = $urandom_range(10, 40);
    end
    send_left--;
    return send_quiet ? 0 : int'($urandom_range(0, 7));
  endfunction

  function automatic int recv_gap();
    if (recv_left == 0) begin
      recv_quiet = ($urandom_range(0, 3) == 0);
      recv_left = $urandom_range(10, 40);
    end
    recv_left--;
    return recv_quiet ? 0 : int'($urandom_range(0, 7));
  endfunction

  task automatic send_and_predict(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                  input logic [WORD_W-1:0] word,
                                  input logic [LEN_W-1:0] len, input bit use_pred);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    symbol <= sym;
    code_word <= word;
    code_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pack_word(op, sym, word, len);
    if (use_pred) begin
      foreach (pred_bytes[j]) bytes_due.push_back(pred_bytes[j]);
    end
  endtask

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin : check_bytes
    out_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (bytes_due.size() == 0) begin
        $error("packed_byte: no word expected, actual %h", packed_byte);
        errors++;
      end else begin
        want = bytes_due.pop_front();
        if (packed_byte !== want.data) begin
          $error("packed_byte: expected %h, actual %h", want.data, packed_byte);
          errors++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %b, actual %b", want.last, last_of_run);
          errors++;
        end
      end
    end
  end

  // A long hold-off lets the sender fill the block until it stalls its input.
  initial begin : receiver
    int gap;
    int taken;
    taken = 0;
    wait (!rst);
    forever begin
      gap = (taken == HOLD_AT) ? HOLD_CYCLES : recv_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : sender
    stim_row_t         r;
    out_byte_t         ob;
    int                pick;
    int                lsel;
    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  sym;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
    dir_rows = '{
      '{OP_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd32, 1'b1, 3'd0, 32'h0},
      '{OP_ENCODE, 8'd0,   32'h0,         6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF},
      '{OP_LOAD,   8'd255, 32'h0,         6'd8,  1'b1, 3'd0, 32'h0},
      '{OP_ENCODE, 8'd255, 32'h0,         6'd0,  1'b1, 3'd1, 32'h0},
      '{OP_LOAD,   8'd1,   32'h0000_00A5, 6'd63, 1'b1, 3'd0, 32'h0},
      '{OP_ENCODE, 8'd1,   32'hFFFF_FFFF, 6'd63, 1'b1, 3'd4, 32'h0000_00A5},
      '{OP_LOAD,   8'd2,   32'hFFFF_FFFF, 6'd0,  1'b1, 3'd0, 32'h0},
      '{OP_ENCODE, 8'd2,   32'h0,         6'd0,  1'b1, 3'd0, 32'h0},
      '{OP_FLUSH,  8'd255, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0},
      '{OP_LOAD,   8'd5,   32'hFFFF_FFFF, 6'd4,  1'b1, 3'd0, 32'h0},
      '{OP_ENCODE, 8'd5,   32'h0,         6'd0,  1'b1, 3'd0, 32'h0},
      '{OP_FLUSH,  8'd0,   32'h0,         6'd0,  1'b1, 3'd1, 32'h0000_00F0},
      '{OP_LOAD,   8'd3,   32'h0000_0005, 6'd3,  1'b1, 3'd0, 32'h0},
      '{OP_LOAD,   8'd4,   32'h0000_007F, 6'd7,  1'b1, 3'd0, 32'h0},
      '{OP_ENCODE, 8'd4,   32'h0,         6'd0,  1'b1, 3'd0, 32'h0},
      '{OP_ENCODE, 8'd3,   32'h0,         6'd0,  1'b0, 3'd0, 32'h0},
      '{OP_ENCODE, 8'd0,   32'h0,         6'd0,  1'b0, 3'd0, 32'h0},
      '{OP_FLUSH,  8'd0,   32'h0,         6'd0,  1'b0, 3'd0, 32'h0},
      '{OP_LOAD,   8'd128, 32'hDEAD_BEEF, 6'd31, 1'b1, 3'd0, 32'h0},
      '{OP_ENCODE, 8'd128, 32'h0,         6'd0,  1'b0, 3'd0, 32'h0},
      '{OP_ENCODE, 8'd128, 32'h0,         6'd0,  1'b0, 3'd0, 32'h0},
      '{OP_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0},
      '{OP_FLUSH,  8'd0,   32'h0,         6'd0,  1'b0, 3'd0, 32'h0},
      '{OP_LOAD,   8'd6,   32'hFFFF_FFFF, 6'd33, 1'b1, 3'd0, 32'h0},
      '{OP_ENCODE, 8'd6,   32'h0,         6'd0,  1'b0, 3'd0, 32'h0}
    };
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      send_and_predict(r.op, r.sym, r.word, r.len, !r.typed);
      if (r.typed) begin
        for (int j = 0; j < int'(r.count); j++) begin
          ob.data = r.bytes[8 * (int'(r.count) - 1 - j) +: 8];
          ob.last = (j == int'(r.count) - 1);
          bytes_due.push_back(ob);
        end
      end
    end

    // Encodes only name symbols that have been loaded at least once.
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      pick = $urandom_range(0, 99);
      sym = SYM_W'($urandom);
      word = $urandom;
      len = LEN_W'($urandom);
      if (pick < 18) begin
        op = OP_LOAD;
        lsel = $urandom_range(0, 99);
        if (lsel < 5) begin
          len = '0;
        end else if (lsel < 12) begin
          len = LEN_W'($urandom_range(33, 63));
        end else if (lsel < 70) begin
          len = LEN_W'($urandom_range(1, 12));
        end else begin
          len = LEN_W'($urandom_range(13, 32));
        end
      end else if (pick < 85) begin
        op = OP_ENCODE;
        sym = SYM_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
      end else if (pick < 96) begin
        op = OP_FLUSH;
      end else begin
        op = OP_UNUSED;
      end
      send_and_predict(op, sym, word, len, 1'b1);
    end
    in_valid <= 1'b0;

    while (bytes_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
